FILE: rtl/assert_macros.svh
// Assertion macros used by the allocator top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Implication checked at every rising clock edge, off during reset.
`define FIPA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition that must hold at every rising clock edge, off during reset.
`define FIPA_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`else
`define FIPA_ASSERT(label, clk, rst_n, prop, msg)
`define FIPA_ASSERT_ALWAYS(label, clk, rst_n, cond, msg)
`endif
`endif

FILE: rtl/fipa_pkg.sv
// Package for the free index pool allocator: sizes, codes and types.
`timescale 1ns / 1ps
package fipa_pkg;
    localparam int POOL_CAPACITY = 1024;
    localparam int RING_DEPTH    = POOL_CAPACITY + 1;
    localparam int OFF_W         = $clog2(POOL_CAPACITY);
    localparam int PTR_W         = $clog2(RING_DEPTH);
    localparam int IDX_W         = 16;
    localparam int SIZE_W        = 11;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 16;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_INDEX = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_SIZE  = 2'd1;

    // Operation codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_REJECT = 2'd1;
    localparam logic [1:0] ST_NOFREE = 2'd2;

    typedef enum logic [0:0] {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } fipa_state_t;
endpackage

FILE: rtl/fipa_ram.sv
// Generic single write port RAM with one registered read port.
`timescale 1ns / 1ps
module fipa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

FILE: rtl/free_index_pool_allocator_top.sv
// Top level of the free index pool allocator.
// Hands out and takes back indices base_index .. base_index+pool_size-1 (modulo 65536),
// one request word at a time: a word is accepted in S_IDLE, which reads the free ring and the
// busy flags (two RAMs with a registered read), and its result is written into the output
// register in S_EXEC together with the write-back. S_EXEC waits while the output register
// still holds a word that has not been taken.
// A configuration write rebuilds the pool directly: a count of first-pass pops stands
// in for the initial ring contents and the cleared busy flags, so there is no clearing pass.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module free_index_pool_allocator_top
    import fipa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // request channel
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  op,
    input  logic [IDX_W-1:0]      index,
    // result channel
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            status,
    output logic [IDX_W-1:0]      granted_index,
    // configuration channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);
    fipa_state_t        state_reg, state_next;
    logic [IDX_W-1:0]   base_reg;
    logic [PTR_W-1:0]   eff_size_reg;
    logic [PTR_W-1:0]   head_reg, head_next;
    logic [PTR_W-1:0]   tail_reg, tail_next;
    logic [PTR_W-1:0]   pop_cnt_reg, pop_cnt_next;
    logic               op_reg;
    logic [IDX_W-1:0]   off_reg;
    logic               out_valid_reg, out_valid_next;
    logic [1:0]         status_reg, status_next;
    logic [IDX_W-1:0]   granted_reg, granted_next;

    logic               in_fire, cfg_fire, out_load;
    logic [IDX_W-1:0]   in_off;
    logic [PTR_W-1:0]   new_eff;
    logic               rebuild;

    logic               ring_we, ring_re;
    logic [PTR_W-1:0]   ring_waddr;
    logic [OFF_W-1:0]   ring_wdata, ring_q;
    logic               busy_we, busy_re;
    logic [OFF_W-1:0]   busy_waddr;
    logic               busy_wdata, busy_q;

    logic               first_pass;
    logic [OFF_W-1:0]   pop_off;
    logic               busy_now;
    logic [PTR_W-1:0]   head_adv, tail_adv;

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign in_fire   = in_valid && in_ready;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign in_off    = index - base_reg;

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign granted_index = granted_reg;

    // Configuration decode: a known register rebuilds the pool
    always_comb
    begin
        rebuild = 1'b0;
        unique case (cfg_index)
            CFG_BASE_INDEX: rebuild = cfg_fire;
            CFG_POOL_SIZE:  rebuild = cfg_fire;
            default:        rebuild = 1'b0;
        endcase
    end

    // Saturated pool size of a new pool_size word
    always_comb
    begin
        if (int'(cfg_data[SIZE_W-1:0]) > POOL_CAPACITY)
        begin
            new_eff = PTR_W'(POOL_CAPACITY);
        end
        else
        begin
            new_eff = PTR_W'(cfg_data[SIZE_W-1:0]);
        end
    end

    // Ring pointer advance: wraps after slot eff_size
    assign head_adv = (head_reg == eff_size_reg) ? '0 : head_reg + 1'b1;
    assign tail_adv = (tail_reg == eff_size_reg) ? '0 : tail_reg + 1'b1;

    // Until the first pass completes, the head slot still holds its initial offset
    assign first_pass = (pop_cnt_reg < eff_size_reg);
    assign pop_off    = first_pass ? head_reg[OFF_W-1:0] : ring_q;
    // Offsets never popped since the rebuild read as idle
    assign busy_now   = (int'(off_reg) < int'(pop_cnt_reg)) ? busy_q : 1'b0;

    // Next state, datapath and RAM controls
    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        pop_cnt_next   = pop_cnt_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        granted_next   = granted_reg;
        out_load       = 1'b0;
        ring_re        = 1'b0;
        busy_re        = 1'b0;
        ring_we        = 1'b0;
        ring_waddr     = tail_reg;
        ring_wdata     = off_reg[OFF_W-1:0];
        busy_we        = 1'b0;
        busy_waddr     = off_reg[OFF_W-1:0];
        busy_wdata     = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    ring_re    = 1'b1;
                    busy_re    = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    granted_next   = '0;
                    state_next     = S_IDLE;
                    if (op_reg == OP_ALLOC)
                    begin
                        if (head_reg != tail_reg)
                        begin
                            busy_we      = 1'b1;
                            busy_waddr   = pop_off;
                            busy_wdata   = 1'b1;
                            granted_next = base_reg + IDX_W'(pop_off);
                            head_next    = head_adv;
                            if (first_pass)
                            begin
                                pop_cnt_next = pop_cnt_reg + 1'b1;
                            end
                            status_next  = ST_OK;
                        end
                        else
                        begin
                            status_next = ST_NOFREE;
                        end
                    end
                    else
                    begin
                        if (int'(off_reg) >= int'(eff_size_reg))
                        begin
                            status_next = ST_REJECT;
                        end
                        else if (tail_adv == head_reg)
                        begin
                            status_next = ST_REJECT;
                        end
                        else
                        begin
                            if (busy_now)
                            begin
                                ring_we   = 1'b1;
                                busy_we   = 1'b1;
                                tail_next = tail_adv;
                            end
                            status_next = ST_OK;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // A rebuild restarts the ring
        if (rebuild)
        begin
            head_next    = '0;
            pop_cnt_next = '0;
            if (cfg_index == CFG_POOL_SIZE)
            begin
                tail_next = new_eff;
            end
            else
            begin
                tail_next = eff_size_reg;
            end
        end
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= '0;
            eff_size_reg  <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            pop_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            pop_cnt_reg   <= pop_cnt_next;
            out_valid_reg <= out_valid_next;
            if (rebuild && cfg_index == CFG_BASE_INDEX)
            begin
                base_reg <= cfg_data[IDX_W-1:0];
            end
            if (rebuild && cfg_index == CFG_POOL_SIZE)
            begin
                eff_size_reg <= new_eff;
            end
        end
    end

    // Request and result payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg  <= op;
            off_reg <= in_off;
        end
        if (out_load)
        begin
            status_reg  <= status_next;
            granted_reg <= granted_next;
        end
    end

    // Free ring: offsets of free indices
    fipa_ram #(
        .WIDTH (OFF_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ring_we),
        .waddr (ring_waddr),
        .wdata (ring_wdata),
        .re    (ring_re),
        .raddr (head_reg),
        .rdata (ring_q)
    );

    // Busy flags, one per offset
    fipa_ram #(
        .WIDTH (1),
        .DEPTH (POOL_CAPACITY)
    ) u_busy (
        .clk   (clk),
        .we    (busy_we),
        .waddr (busy_waddr),
        .wdata (busy_wdata),
        .re    (busy_re),
        .raddr (in_off[OFF_W-1:0]),
        .rdata (busy_q)
    );

    `FIPA_ASSERT_ALWAYS(a_ptr_range, clk, rst_n, head_reg <= eff_size_reg && tail_reg <= eff_size_reg, "ring pointer past pool")
    `FIPA_ASSERT_ALWAYS(a_pop_cnt_range, clk, rst_n, pop_cnt_reg <= eff_size_reg, "pop count past pool")
    `FIPA_ASSERT(a_first_pass_head, clk, rst_n, first_pass |-> head_reg == pop_cnt_reg, "head left first pass early")
    `FIPA_ASSERT(a_accept_exec, clk, rst_n, in_fire |=> state_reg == S_EXEC && !in_ready, "accepted word not executed")
endmodule

FILE: tb/tb_free_index_pool_allocator_top.sv
// Testbench for the free index pool allocator: random and directed requests, scoreboard check.
`timescale 1ns / 1ps
module tb_free_index_pool_allocator_top;
    import fipa_pkg::*;

    // register indexes the block does not decode
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;
    localparam logic [IDX_W-1:0]     TOP_BASE    = 16'hFFFA;
    // pool copies: one follows accepted words, one follows queued words
    localparam int PRED = 0;
    localparam int PLAN = 1;

    typedef struct packed {
        logic             op;
        logic [IDX_W-1:0] idx;
    } req_t;

    typedef struct packed {
        logic [1:0]       st;
        logic [IDX_W-1:0] gi;
    } result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic                  op = OP_ALLOC;
    logic [IDX_W-1:0]      index = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [1:0]            status;
    logic [IDX_W-1:0]      granted_index;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_BASE_INDEX;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    req_t    pending_reqs[$];
    result_t expected_results[$];
    int      errors = 0;
    int      cyc = 0;
    logic    req_taken = 1'b0;
    logic    cfg_taken = 1'b0;
    logic    calm;

    // pool state, one copy per PRED / PLAN
    logic [SIZE_W-1:0] ring    [0:1][0:RING_DEPTH-1];
    logic              busy    [0:1][0:POOL_CAPACITY-1];
    logic [PTR_W-1:0]  head_p  [0:1];
    logic [PTR_W-1:0]  tail_p  [0:1];
    logic [IDX_W-1:0]  base_r  [0:1];
    logic [SIZE_W-1:0] size_r  [0:1];
    logic [SIZE_W-1:0] eff_r   [0:1];

    free_index_pool_allocator_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .index         (index),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .granted_index (granted_index),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // no idling on either side inside this window
    assign calm = (cyc >= 2000) && (cyc < 3500);

    // ---------------- pool model ----------------

    function automatic logic [PTR_W-1:0] ring_succ(input int m, input logic [PTR_W-1:0] p);
        int n;
        n = int'(p) + 1;
        if (n >= int'(eff_r[m]) + 1)
            n = 0;
        return n[PTR_W-1:0];
    endfunction

    function automatic void pool_rebuild(input int m);
        eff_r[m] = (size_r[m] > POOL_CAPACITY) ? SIZE_W'(POOL_CAPACITY) : size_r[m];
        for (int k = 0; k < RING_DEPTH; k++)
            ring[m][k] = SIZE_W'(k);
        for (int k = 0; k < POOL_CAPACITY; k++)
            busy[m][k] = 1'b0;
        head_p[m] = '0;
        tail_p[m] = PTR_W'(eff_r[m]);
    endfunction

    function automatic void pool_write(input int m, input logic [CFG_IDX_W-1:0] ci,
                                       input logic [CFG_DATA_W-1:0] cd);
        if (ci == CFG_BASE_INDEX)
        begin
            base_r[m] = cd[IDX_W-1:0];
            pool_rebuild(m);
        end
        else if (ci == CFG_POOL_SIZE)
        begin
            size_r[m] = cd[SIZE_W-1:0];
            pool_rebuild(m);
        end
        // other indexes: ignored, pool kept as is
    endfunction

    // one request against pool copy m: status and granted index
    function automatic void pool_step(input int m, input logic opc, input logic [IDX_W-1:0] idx,
                                      output logic [1:0] st, output logic [IDX_W-1:0] gi);
        int               off;
        logic [IDX_W-1:0] rel;
        st = ST_NOFREE;
        gi = '0;
        if (opc == OP_ALLOC)
        begin
            if (head_p[m] != tail_p[m])
            begin
                off = int'(ring[m][head_p[m]]);
                if (off < POOL_CAPACITY)
                    busy[m][off] = 1'b1;
                gi = base_r[m] + off[IDX_W-1:0];
                head_p[m] = ring_succ(m, head_p[m]);
                st = ST_OK;
            end
        end
        else
        begin
            rel = idx - base_r[m];
            off = int'(rel);
            if (off >= int'(eff_r[m]) || off >= POOL_CAPACITY)
                st = ST_REJECT;
            else if (ring_succ(m, tail_p[m]) == head_p[m])
                st = ST_REJECT;
            else
            begin
                // freeing an idle index is accepted and changes nothing
                if (busy[m][off])
                begin
                    ring[m][tail_p[m]] = SIZE_W'(off);
                    busy[m][off] = 1'b0;
                    tail_p[m] = ring_succ(m, tail_p[m]);
                end
                st = ST_OK;
            end
        end
    endfunction

    // ---------------- driver, receiver, monitor ----------------

    // request driver: next word from the pending queue, random gaps
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || req_taken))
        begin
            if (pending_reqs.size() != 0 && (calm || $urandom_range(99) >= 12))
            begin
                in_valid <= 1'b1;
                op       <= pending_reqs[0].op;
                index    <= pending_reqs[0].idx;
                void'(pending_reqs.pop_front());
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result side back-pressure
    always @(negedge clk)
    begin
        if (rst_n)
            out_ready <= calm || ($urandom_range(99) >= 12);
    end

    // monitor: predict on accepted requests, check accepted results
    always @(posedge clk)
    begin : mon
        result_t          want;
        result_t          got;
        logic [1:0]       st;
        logic [IDX_W-1:0] gi;
        req_taken = 1'b0;
        cfg_taken = 1'b0;
        if (rst_n)
        begin
            cyc++;
            if (cfg_valid && cfg_ready)
            begin
                cfg_taken = 1'b1;
                pool_write(PRED, cfg_index, cfg_data);
            end
            if (in_valid && in_ready)
            begin
                req_taken = 1'b1;
                pool_step(PRED, op, index, st, gi);
                got.st = st;
                got.gi = gi;
                expected_results.push_back(got);
            end
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result with nothing expected: status=%0d granted_index=%h",
                             $time, status, granted_index);
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (status !== want.st)
                    begin
                        $display("%0t: status expected %0d actual %0d", $time, want.st, status);
                        errors++;
                    end
                    if (granted_index !== want.gi)
                    begin
                        $display("%0t: granted_index expected %h actual %h",
                                 $time, want.gi, granted_index);
                        errors++;
                    end
                end
            end
        end
    end

    // ---------------- stimulus ----------------

    // wait until no request is queued, in flight or owed a result;
    // checked at the rising edge, where the driven inputs are settled
    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0);
        @(negedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] ci, input logic [CFG_DATA_W-1:0] cd);
        wait_drained();
        pool_write(PLAN, ci, cd);
        cfg_valid <= 1'b1;
        cfg_index <= ci;
        cfg_data  <= cd;
        do
            @(negedge clk);
        while (!cfg_taken);
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_req(input logic opc, input logic [IDX_W-1:0] idx);
        req_t             r;
        logic [1:0]       st;
        logic [IDX_W-1:0] gi;
        pool_step(PLAN, opc, idx, st, gi);
        r.op  = opc;
        r.idx = idx;
        pending_reqs.push_back(r);
    endtask

    // allocations at alloc_pct percent, else frees: mostly of handed-out indices, some range edges and noise
    task automatic queue_random(input int alloc_pct);
        logic [IDX_W-1:0] idx;
        int               off;
        int               sel;
        int               tries;
        idx = IDX_W'($urandom);
        if ($urandom_range(99) < alloc_pct)
            queue_req(OP_ALLOC, idx);
        else
        begin
            sel = $urandom_range(99);
            if (eff_r[PLAN] != 0 && sel < 90)
            begin
                off = $urandom_range(int'(eff_r[PLAN]) - 1);
                tries = 0;
                while (sel < 80 && !busy[PLAN][off] && tries < 8)
                begin
                    off = $urandom_range(int'(eff_r[PLAN]) - 1);
                    tries++;
                end
                idx = base_r[PLAN] + off[IDX_W-1:0];
            end
            else if (sel < 95)
                idx = (sel[0]) ? base_r[PLAN] + IDX_W'(eff_r[PLAN]) : base_r[PLAN] - 1'b1;
            queue_req(OP_FREE, idx);
        end
    endtask

    // rebuild the pool, then random traffic with a full drain halfway
    task automatic run_phase(input logic [CFG_DATA_W-1:0] base, input logic [CFG_DATA_W-1:0] sz,
                             input int n, input int alloc_pct);
        cfg_write(CFG_BASE_INDEX, base);
        cfg_write(CFG_POOL_SIZE, sz);
        for (int i = 0; i < n / 2; i++)
            queue_random(alloc_pct);
        wait_drained();
        for (int i = n / 2; i < n; i++)
            queue_random(alloc_pct);
    endtask

    initial
    begin
        pool_write(PRED, CFG_BASE_INDEX, '0);
        pool_write(PRED, CFG_POOL_SIZE, '0);
        pool_write(PLAN, CFG_BASE_INDEX, '0);
        pool_write(PLAN, CFG_POOL_SIZE, '0);
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty pool after reset
        queue_req(OP_ALLOC, 16'h0000);
        queue_req(OP_FREE, 16'hFFFF);

        // eight indices wrapping past the top of the index space
        cfg_write(CFG_BASE_INDEX, TOP_BASE);
        cfg_write(CFG_POOL_SIZE, 16'hF808);
        for (int k = 0; k < 8; k++)
            queue_req(OP_ALLOC, IDX_W'(k * 16'h2111));
        queue_req(OP_ALLOC, 16'hFFFF);        // nothing left
        queue_req(OP_FREE, 16'h0001);         // wrapped index, busy
        queue_req(OP_FREE, 16'h0001);         // now idle
        queue_req(OP_FREE, TOP_BASE - 1'b1);  // just below the pool
        queue_req(OP_FREE, 16'h0002);         // just above the pool
        for (int k = 0; k < 8; k++)
            queue_req(OP_FREE, TOP_BASE + IDX_W'(k));
        queue_req(OP_FREE, TOP_BASE + 1'b1);  // queue full

        // random phases; oversized size saturates to the capacity
        run_phase(16'h0000, 16'h07FF, 250, 75);
        run_phase(16'hFFFF, 16'h0001, 100, 50);
        run_phase(CFG_DATA_W'($urandom), {5'($urandom), 11'd16}, 300, 50);
        // undecoded registers must leave the pool as it is
        cfg_write(CFG_SPARE_2, CFG_DATA_W'($urandom));
        cfg_write(CFG_SPARE_3, CFG_DATA_W'($urandom));
        for (int i = 0; i < 100; i++)
            queue_random(50);
        run_phase(16'hFC00, 16'h0400, 200, 60);
        run_phase(16'h1234, 16'hF800, 30, 50);
        run_phase(16'hFFF0, 16'd40, 300, 45);
        for (int p = 0; p < 5; p++)
            run_phase(CFG_DATA_W'($urandom), {5'($urandom), 11'($urandom_range(64, 1))},
                      140, $urandom_range(65, 35));

        wait_drained();
        repeat (10) @(posedge clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // run limit
    initial
    begin
        #(2_000_000);
        $display("FAIL");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/fipa_pkg.sv
rtl/fipa_ram.sv
rtl/free_index_pool_allocator_top.sv
tb/tb_free_index_pool_allocator_top.sv
